// ===== src/ssd_pkg.sv =====
// Shared types, constants and helpers for the seismic sample decoder.
package ssd_pkg;

   typedef enum logic [2:0] {
      FMT_IBM    = 3'd0,
      FMT_INT32  = 3'd1,
      FMT_INT16  = 3'd2,
      FMT_FIX16  = 3'd3,
      FMT_SINGLE = 3'd4,
      FMT_INT8   = 3'd5,
      FMT_DOUBLE = 3'd6,
      FMT_IBM7   = 3'd7
   } fmt_type;

   localparam logic [0:0] CSR_FORMAT = 1'b0;
   localparam logic [0:0] CSR_ENDIAN = 1'b1;

   // Staged request between the front end and the converter
   typedef struct packed {
      fmt_type     fmt;
      logic [63:0] word;
   } stage_type;

   // Byte-swap the low n bytes (n = 1, 2, 4 or 8)
   function automatic logic [63:0] swap_bytes(input logic [63:0] x, input logic [3:0] n);
      logic [63:0] r;
      r = '0;
      case (n)
         4'd1: r = {56'd0, x[7:0]};
         4'd2: r = {48'd0, x[7:0], x[15:8]};
         4'd4: r = {32'd0, x[7:0], x[15:8], x[23:16], x[31:24]};
         default: r = {x[7:0], x[15:8], x[23:16], x[31:24],
                       x[39:32], x[47:40], x[55:48], x[63:56]};
      endcase
      return r;
   endfunction

   // Index of the highest set bit of a 32-bit value (0 when zero)
   function automatic logic [4:0] msb32(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

// ===== src/ssd_front.sv =====
// Input register: byte selection and byte-order correction.
module ssd_front import ssd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  fmt_type     fmt,
   input  logic        big_endian,
   input  logic [63:0] sample_bytes,
   output logic        stage_valid,
   output stage_type   stage
);
   logic [3:0]  nbytes;
   logic [63:0] masked;
   logic        valid_ff, valid_in;
   stage_type   stage_ff, stage_in;

   // Sample width in bytes by format
   always_comb begin
      case (fmt)
         FMT_INT16:  nbytes = 4'd2;
         FMT_INT8:   nbytes = 4'd1;
         FMT_DOUBLE: nbytes = 4'd8;
         default:    nbytes = 4'd4;
      endcase
   end

   // Drop unused high bytes, then fix the byte order
   always_comb begin
      case (nbytes)
         4'd1: masked = {56'd0, sample_bytes[7:0]};
         4'd2: masked = {48'd0, sample_bytes[15:0]};
         4'd4: masked = {32'd0, sample_bytes[31:0]};
         default: masked = sample_bytes;
      endcase
      stage_in.fmt  = fmt;
      stage_in.word = big_endian ? masked : swap_bytes(masked, nbytes);
      valid_in      = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;
endmodule

// ===== src/ssd_convert.sv =====
// Result register: normalize and repack to double.
module ssd_convert import ssd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        stage_valid,
   input  stage_type   stage,
   output logic        rsp_valid,
   output logic [63:0] value_bits
);
   logic [63:0] w, res_in, res_ff;
   logic        valid_ff;
   logic [31:0] ival, mag;
   logic        isign;
   logic [4:0]  p;
   logic [10:0] ebias;
   logic [63:0] shifted;
   logic [23:0] ibm_f;
   logic [6:0]  ibm_e;
   logic [22:0] sm;
   logic [7:0]  se;
   logic [4:0]  pi, ps;
   logic [63:0] ibm_sh, sgl_sh;

   assign w = stage.word;

   // Integer and fixed formats share one sign-magnitude normalizer
   always_comb begin
      case (stage.fmt)
         FMT_INT16: ival = {{16{w[15]}}, w[15:0]};
         FMT_INT8:  ival = {{24{w[7]}}, w[7:0]};
         default:   ival = w[31:0];
      endcase
      isign   = ival[31];
      mag     = isign ? (32'd0 - ival) : ival;
      p       = msb32(mag);
      ebias   = (stage.fmt == FMT_FIX16) ? 11'(1023 - 16) : 11'd1023;
      shifted = {32'd0, mag} << (6'd52 - {1'b0, p});
   end

   // IBM and single-precision fields
   always_comb begin
      ibm_f  = w[23:0];
      ibm_e  = w[30:24];
      pi     = msb32({8'd0, ibm_f});
      ibm_sh = {40'd0, ibm_f} << (6'd52 - {1'b0, pi});
      sm     = w[22:0];
      se     = w[30:23];
      ps     = msb32({9'd0, sm});
      sgl_sh = {41'd0, sm} << (6'd52 - {1'b0, ps});
   end

   // Repack by format
   always_comb begin
      case (stage.fmt)
         FMT_INT32, FMT_INT16, FMT_INT8, FMT_FIX16: begin
            if (mag == 32'd0) res_in = '0;
            else res_in = {isign, 11'(ebias + 11'(p)), shifted[51:0]};
         end
         FMT_SINGLE: begin
            if (se == 8'hFF)
               res_in = {w[31], 11'h7FF, sm, 29'd0};
            else if (se == 8'd0) begin
               if (sm == 23'd0) res_in = {w[31], 63'd0};
               else res_in = {w[31], 11'(11'd874 + 11'(ps)), sgl_sh[51:0]};
            end else
               res_in = {w[31], 11'(11'd896 + 11'(se)), sm, 29'd0};
         end
         FMT_DOUBLE: res_in = w;
         default: begin
            if (ibm_f == 24'd0) res_in = '0;
            else res_in = {w[31],
                           11'(11'(pi) + {2'd0, ibm_e, 2'd0} + 11'd743),
                           ibm_sh[51:0]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_valid;
      end
      if (stage_valid) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign value_bits = res_ff;
endmodule

// ===== src/seismic_sample_to_ieee_double_core.sv =====
// Top level: seismic trace sample to IEEE double converter.
//  channel   handshake              payload
//  req       start / busy           req_sample_bytes[63:0]
//  rsp       rsp_valid strobe       rsp_value_bits[63:0]
//  csr       csr_valid / csr_ready  csr_index, csr_data[2:0]
// One request per cycle; each result passes the input register, then the
// result register. busy is always low; csr_ready is always high.
// Reset clears the valid pipeline and sets format IBM, big-endian.
// The receiver cannot stall; results appear as one-cycle strobes.
module seismic_sample_to_ieee_double_core import ssd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_sample_bytes,
   output logic        rsp_valid,
   output logic [63:0] rsp_value_bits,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [2:0]  csr_data
);
   fmt_type   fmt_ff;
   logic      endian_ff;
   logic      take;
   logic      stage_valid;
   stage_type stage;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign take      = start & ~busy;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_IBM;
         endian_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FORMAT) fmt_ff <= fmt_type'(csr_data);
         if (csr_index == CSR_ENDIAN) endian_ff <= csr_data[0];
      end
   end

   ssd_front u_front (
      .clock(clock), .reset(reset), .take(take), .fmt(fmt_ff),
      .big_endian(endian_ff), .sample_bytes(req_sample_bytes),
      .stage_valid(stage_valid), .stage(stage)
   );

   ssd_convert u_convert (
      .clock(clock), .reset(reset), .stage_valid(stage_valid), .stage(stage),
      .rsp_valid(rsp_valid), .value_bits(rsp_value_bits)
   );

   // A result strobe follows each request, through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |=> ##1 rsp_valid) else $error("missing result");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(stage_valid)) else $error("spurious result");
   a_double_pass: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && stage.fmt == FMT_DOUBLE) |=> rsp_value_bits == $past(stage.word))
      else $error("double not passed through");
endmodule
